### sv/pbu_pkg.sv
package pbu_pkg;

  // blend mode codes as held in the mode register
  typedef enum logic [1:0] {
    MODE_MULTIPLY = 2'd0,
    MODE_SCREEN   = 2'd1,
    MODE_MIX      = 2'd2,
    MODE_PASS     = 2'd3
  } mode_t;

  localparam int unsigned CHANNELS  = 4;
  localparam int unsigned CH_ALPHA  = 3;
  localparam logic [7:0]  CH_MAX    = 8'hFF;

  // rounded divide by 255: (x + 127) * 32897 >> 23, exact for x + 127 < 65536
  localparam logic [16:0] DIV_ROUND    = 17'd127;
  localparam logic [16:0] DIV255_RECIP = 17'd32897;
  localparam int unsigned DIV255_SHIFT = 23;

  // luma weights and divide by 1000 as 268436 >> 28, exact below 2^18
  localparam logic [17:0] LUMA_R       = 18'd299;
  localparam logic [17:0] LUMA_G       = 18'd587;
  localparam logic [17:0] LUMA_B       = 18'd114;
  localparam logic [17:0] LUMA_ROUND   = 18'd500;
  localparam logic [18:0] LUMA_RECIP   = 19'd268436;
  localparam int unsigned LUMA_SHIFT   = 28;

  // one pixel request as it arrives
  typedef struct packed {
    logic [7:0]            blend_alpha;
    logic [3:0][7:0]       over;
    logic [3:0][7:0]       base;
  } pix_t;

  // after the product stage
  typedef struct packed {
    mode_t                 mode;
    logic [3:0][7:0]       base;
    logic [3:0][15:0]      prod;
    logic [17:0]           luma_sum;
    logic [9:0]            delta;
  } prod_t;

  // after the divide stage
  typedef struct packed {
    mode_t                 mode;
    logic [3:0][7:0]       base;
    logic [3:0][7:0]       quot;
    logic [7:0]            gray;
    logic [9:0]            delta;
  } quot_t;

  // final result
  typedef struct packed {
    logic [9:0]            delta;
    logic [7:0]            gray;
    logic [3:0][7:0]       chan;
  } result_t;

  function automatic logic [15:0] mul8(input logic [7:0] x, input logic [7:0] y);
    mul8 = {8'd0, x} * {8'd0, y};
  endfunction

  function automatic logic [7:0] absdiff8(input logic [7:0] x, input logic [7:0] y);
    absdiff8 = (x > y) ? (x - y) : (y - x);
  endfunction

endpackage

### sv/pbu_product.sv
module pbu_product (
  input  logic               clk,
  input  logic               rst,
  input  pbu_pkg::mode_t     mode,
  input  logic               in_valid,
  output logic               in_ready,
  input  pbu_pkg::pix_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pbu_pkg::prod_t     out_data
);

  pbu_pkg::prod_t stage_next;
  logic           valid;

  // per channel product, luma sum and channel differences
  always_comb begin
    stage_next      = '0;
    stage_next.mode = mode;
    stage_next.base = in_data.base;
    for (int c = 0; c < pbu_pkg::CHANNELS; c++) begin
      case (mode)
        pbu_pkg::MODE_MULTIPLY: begin
          stage_next.prod[c] = pbu_pkg::mul8(in_data.base[c], in_data.over[c]);
        end
        pbu_pkg::MODE_SCREEN: begin
          stage_next.prod[c] = pbu_pkg::mul8(pbu_pkg::CH_MAX - in_data.base[c],
                                             in_data.over[c]);
        end
        pbu_pkg::MODE_MIX: begin
          stage_next.prod[c] =
            pbu_pkg::mul8(in_data.base[c], pbu_pkg::CH_MAX - in_data.blend_alpha) +
            pbu_pkg::mul8(in_data.over[c], in_data.blend_alpha);
        end
        default: begin
          stage_next.prod[c] = '0;
        end
      endcase
    end
    stage_next.luma_sum = pbu_pkg::LUMA_R * {10'd0, in_data.base[0]} +
                          pbu_pkg::LUMA_G * {10'd0, in_data.base[1]} +
                          pbu_pkg::LUMA_B * {10'd0, in_data.base[2]} +
                          pbu_pkg::LUMA_ROUND;
    stage_next.delta = {2'd0, pbu_pkg::absdiff8(in_data.base[0], in_data.over[0])} +
                       {2'd0, pbu_pkg::absdiff8(in_data.base[1], in_data.over[1])} +
                       {2'd0, pbu_pkg::absdiff8(in_data.base[2], in_data.over[2])};
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

### sv/pbu_divide.sv
module pbu_divide (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pbu_pkg::prod_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pbu_pkg::quot_t     out_data
);

  pbu_pkg::quot_t stage_next;
  logic [33:0]    chan_full [pbu_pkg::CHANNELS];
  logic [36:0]    luma_full;
  logic           valid;

  // rounded divide by 255 per channel and divide by 1000 for luma
  always_comb begin
    stage_next       = '0;
    stage_next.mode  = in_data.mode;
    stage_next.base  = in_data.base;
    stage_next.delta = in_data.delta;
    for (int c = 0; c < pbu_pkg::CHANNELS; c++) begin
      chan_full[c] = {17'd0, {1'b0, in_data.prod[c]} + pbu_pkg::DIV_ROUND} *
                     {17'd0, pbu_pkg::DIV255_RECIP};
      stage_next.quot[c] = chan_full[c][pbu_pkg::DIV255_SHIFT +: 8];
    end
    luma_full       = {19'd0, in_data.luma_sum} * {18'd0, pbu_pkg::LUMA_RECIP};
    stage_next.gray = luma_full[pbu_pkg::LUMA_SHIFT +: 8];
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

### sv/pbu_select.sv
module pbu_select (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pbu_pkg::quot_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pbu_pkg::result_t   out_data
);

  pbu_pkg::result_t stage_next;
  logic             valid;

  // pick the channel result for the mode
  always_comb begin
    stage_next       = '0;
    stage_next.gray  = in_data.gray;
    stage_next.delta = in_data.delta;
    for (int c = 0; c < pbu_pkg::CHANNELS; c++) begin
      case (in_data.mode)
        pbu_pkg::MODE_MULTIPLY: begin
          stage_next.chan[c] = in_data.quot[c];
        end
        pbu_pkg::MODE_SCREEN: begin
          stage_next.chan[c] = in_data.base[c] + in_data.quot[c];
        end
        pbu_pkg::MODE_MIX: begin
          stage_next.chan[c] = (c == pbu_pkg::CH_ALPHA) ? in_data.base[c]
                                                        : in_data.quot[c];
        end
        default: begin
          stage_next.chan[c] = in_data.base[c];
        end
      endcase
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

### sv/pixel_blend_unit.sv
// Pixel compositor taking one request per clock: a base RGBA pixel, an overlay
// RGBA pixel and a blend alpha. blend_mode selects multiply, screen or alpha
// blend (mode 3 passes the base pixel through); every result also carries the
// rounded BT.601 gray level of the base and the sum of absolute RGB differences.
// The product, divide and select stages each register their result, and a
// new request is taken every cycle while s_axis_tready is high; each stage has
// its own valid bit, so the input keeps flowing into empty stages while a
// result waits on m_axis_tready. blend_mode is sampled as a request enters
// and should only be written while the pipeline is empty.
module pixel_blend_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // base_red, base_green, base_blue, base_alpha, over_red, over_green,
  // over_blue, over_alpha, blend_alpha
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red, out_green, out_blue, out_alpha, gray_level, delta_sum, zero pad
  output logic [55:0] m_axis_tdata
);

  pbu_pkg::mode_t   blend_mode;
  pbu_pkg::pix_t    pix;
  pbu_pkg::prod_t   prod_data;
  pbu_pkg::quot_t   quot_data;
  pbu_pkg::result_t result;
  logic             prod_valid;
  logic             prod_ready;
  logic             quot_valid;
  logic             quot_ready;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= pbu_pkg::MODE_MULTIPLY;
    end else if (cfg_write) begin
      blend_mode <= pbu_pkg::mode_t'(cfg_data);
    end
  end

  // unpack the request
  assign pix.base        = s_axis_tdata[31:0];
  assign pix.over        = s_axis_tdata[63:32];
  assign pix.blend_alpha = s_axis_tdata[71:64];

  pbu_product u_product (
    .clk       (clk),
    .rst       (rst),
    .mode      (blend_mode),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (pix),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  pbu_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (quot_valid),
    .out_ready (quot_ready),
    .out_data  (quot_data)
  );

  pbu_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quot_valid),
    .in_ready  (quot_ready),
    .in_data   (quot_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (result)
  );

  // pack the result
  assign m_axis_tdata = {6'd0, result.delta, result.gray, result.chan};

  // multiply never brightens the red or green channel
  assert property (@(posedge clk) disable iff (rst)
    quot_valid && quot_data.mode == pbu_pkg::MODE_MULTIPLY
      |-> quot_data.quot[0] <= quot_data.base[0] && quot_data.quot[1] <= quot_data.base[1])
    else $error("multiply quotient exceeds base channel");

  // screen never carries out of eight bits on the red or alpha channel
  assert property (@(posedge clk) disable iff (rst)
    quot_valid && quot_data.mode == pbu_pkg::MODE_SCREEN
      |-> ({1'b0, quot_data.base[0]} + {1'b0, quot_data.quot[0]}) <= 9'd255 &&
          ({1'b0, quot_data.base[3]} + {1'b0, quot_data.quot[3]}) <= 9'd255)
    else $error("screen result overflows");

  // difference sum stays within three full-scale channels
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[49:40] <= 10'd765)
    else $error("delta sum out of range");

endmodule

### sim/pixel_blend_unit_tb.sv
module pixel_blend_unit_tb;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned CHUNK_ITEMS  = 100;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  // mode as last written into the block
  pbu_pkg::mode_t   cur_mode;
  // blends still owed by the block, oldest first
  pbu_pkg::result_t pending_results[$];
  int unsigned      mismatches;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      quiet_cycles;
  pbu_pkg::result_t want_result;
  pbu_pkg::result_t got_result;

  const pbu_pkg::mode_t all_modes[4] = '{pbu_pkg::MODE_MULTIPLY, pbu_pkg::MODE_SCREEN,
                                         pbu_pkg::MODE_MIX, pbu_pkg::MODE_PASS};
  const string chan_name[4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

  pixel_blend_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // composite one pixel the way the block should
  function automatic pbu_pkg::result_t blend_pixel(input pbu_pkg::pix_t p,
                                                   input pbu_pkg::mode_t m);
    pbu_pkg::result_t r;
    int unsigned b;
    int unsigned o;
    int unsigned a;
    int unsigned v;
    int unsigned dsum;
    a = p.blend_alpha;
    dsum = 0;
    for (int c = 0; c < 4; c++) begin
      b = p.base[c];
      o = p.over[c];
      case (m)
        pbu_pkg::MODE_MULTIPLY: begin
          v = (b * o + 127) / 255;
        end
        pbu_pkg::MODE_SCREEN: begin
          v = b + ((255 - b) * o + 127) / 255;
        end
        pbu_pkg::MODE_MIX: begin
          // alpha blend leaves the base alpha alone
          v = (c == pbu_pkg::CH_ALPHA) ? b : (b * (255 - a) + o * a + 127) / 255;
        end
        default: begin
          v = b;
        end
      endcase
      r.chan[c] = 8'(v);
      if (c != pbu_pkg::CH_ALPHA) begin
        dsum += (b > o) ? b - o : o - b;
      end
    end
    r.gray  = 8'((299 * p.base[0] + 587 * p.base[1] + 114 * p.base[2] + 500) / 1000);
    r.delta = 10'(dsum);
    return r;
  endfunction

  // one field compare, only the first few get printed
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  // hand one request to the block, with a random gap in front
  task automatic send_pixel(input pbu_pkg::pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(blend_pixel(p, cur_mode));
    @(negedge clk);
  endtask

  // stop sending and let every outstanding blend come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // mode change, only with the pipeline empty
  task automatic write_mode(input pbu_pkg::mode_t m);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= m;
    cur_mode  = m;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // channel extremes and mixed corners under every mode, mode 3 included
  task automatic test_directed();
    // packed as blend, overlay abgr, base abgr
    pbu_pkg::pix_t corners[6] = '{
      72'h00_00000000_00000000,
      72'hFF_FFFFFFFF_FFFFFFFF,
      72'h00_00000000_FFFFFFFF,
      72'hFF_FFFFFFFF_00000000,
      72'h80_FEFF7F00_010080FF,
      72'h01_4000FFFF_80FF0000
    };
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (all_modes[i]) begin
      write_mode(all_modes[i]);
      foreach (corners[k]) begin
        send_pixel(corners[k]);
      end
    end
  endtask

  // random pixels under each idling phase and each mode
  task automatic test_random();
    int unsigned   send_pct[4]  = '{0, 57, 0, 9};
    int unsigned   stall_pct[4] = '{0, 0, 57, 9};
    pbu_pkg::pix_t p;
    logic [71:0]   raw;
    for (int ph = 0; ph < 4; ph++) begin
      foreach (all_modes[i]) begin
        write_mode(all_modes[i]);
        send_idle_pct  = send_pct[ph];
        recv_stall_pct = stall_pct[ph];
        repeat (CHUNK_ITEMS) begin
          // mostly uniform channels, with a bias towards 0 and 255
          for (int f = 0; f < 9; f++) begin
            case ($urandom_range(9))
              0:       raw[f*8 +: 8] = 8'h00;
              1:       raw[f*8 +: 8] = 8'hFF;
              default: raw[f*8 +: 8] = 8'($urandom_range(255));
            endcase
          end
          p = raw;
          send_pixel(p);
        end
      end
    end
  endtask

  // output back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each accepted result with the oldest blend owed
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("result with no request outstanding: %h", m_axis_tdata);
        end
      end else begin
        want_result = pending_results.pop_front();
        got_result  = m_axis_tdata[49:0];
        for (int c = 0; c < 4; c++) begin
          check_field(chan_name[c], want_result.chan[c], got_result.chan[c]);
        end
        check_field("gray_level", want_result.gray, got_result.gray);
        check_field("delta_sum", want_result.delta, got_result.delta);
        check_field("zero pad", 0, m_axis_tdata[55:50]);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_data       = pbu_pkg::MODE_MULTIPLY;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cur_mode       = pbu_pkg::MODE_MULTIPLY;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random();
    wait_drained();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
